// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by ray_box_slab_intersect_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rbsi_pkg.sv =====
// Package for the ray versus box slab intersection block
package rbsi_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 24;
  localparam int NUM_AXES   = 3;
  localparam int NUM_FIELDS = 12;

endpackage

// ===== rtl/core/ray_box_slab_intersect_top.sv =====
// Ray versus axis-aligned box slab test, fully pipelined
//
//  channel | dir | transaction payload
//  in_     | in  | ray origin, ray direction, box min corner, box max corner
//  out_    | out | hit flag and hit distance
//
// One transaction per cycle sustained while the pipeline is not held (see below).
// Stages: input register, divider setup, COORD_BITS - 1 quotient-bit stages of the
// 6 restoring dividers, three post stages and the output register.
// Reset (rst_n low, synchronous) clears all stage valid bits.
// The whole pipeline holds while out_tvalid is high and out_tready is low;
// in_tready follows that hold.
module ray_box_slab_intersect_top #(
  parameter int COORD_BITS = rbsi_pkg::COORD_BITS,
  parameter int FRAC_BITS  = rbsi_pkg::FRAC_BITS,
  parameter int IN_W       = ((rbsi_pkg::NUM_FIELDS * COORD_BITS + 7) / 8) * 8,
  parameter int OUT_W      = ((COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // hit, hit_distance
  output logic [OUT_W-1:0] out_tdata
);

`include "assert_macros.svh"

  localparam int CB = COORD_BITS;
  localparam int FB = FRAC_BITS;
  localparam int D  = CB - 1;
  localparam int NA = rbsi_pkg::NUM_AXES;
  localparam int NK = 2 * rbsi_pkg::NUM_AXES;
  localparam int CW = (FB + 1 > CB) ? FB + 1 : CB;
  localparam logic [CB-1:0] TMAX    = {1'b0, {D{1'b1}}};
  localparam logic [CB-1:0] PAR_LIM = CB'((64'd1 << FB) / 64'd1000000);

  logic adv;
  assign adv       = ~out_tvalid | out_tready;
  assign in_tready = adv;

  // ---------------- stage 1: differences and magnitudes
  logic                   s1_vld_r;
  logic [CB-1:0]          s1_dmag_r [NA];
  logic                   s1_dneg_r [NA];
  logic                   s1_pm_r   [NA];
  logic [CB-1:0]          s1_nmag_r [NK];
  logic                   s1_nneg_r [NK];

  logic [CB-1:0]          s1_dmag_nxt [NA];
  logic                   s1_dneg_nxt [NA];
  logic                   s1_pm_nxt   [NA];
  logic [CB-1:0]          s1_nmag_nxt [NK];
  logic                   s1_nneg_nxt [NK];

  always_comb begin
    logic signed [CB-1:0] o, d, lo, hi;
    logic signed [CB:0]   df;
    for (int a = 0; a < NA; a++) begin
      o  = in_tdata[a*CB +: CB];
      d  = in_tdata[(3+a)*CB +: CB];
      lo = in_tdata[(6+a)*CB +: CB];
      hi = in_tdata[(9+a)*CB +: CB];
      s1_dneg_nxt[a] = d[CB-1];
      s1_dmag_nxt[a] = d[CB-1] ? CB'(-d) : d;
      s1_pm_nxt[a]   = (o < lo) || (o > hi);
      df = {lo[CB-1], lo} - {o[CB-1], o};
      s1_nneg_nxt[2*a]   = df[CB];
      s1_nmag_nxt[2*a]   = df[CB] ? CB'(-df) : CB'(df);
      df = {hi[CB-1], hi} - {o[CB-1], o};
      s1_nneg_nxt[2*a+1] = df[CB];
      s1_nmag_nxt[2*a+1] = df[CB] ? CB'(-df) : CB'(df);
    end
  end

  // ---------------- divider stages: index 0 is setup, 1..D one quotient bit each
  logic                   dv_vld_r [D+1];
  logic [CB-1:0]          dv_rem_r [D+1][NK];
  logic [D-1:0]           dv_q_r   [D+1][NK];
  logic [D-1:0]           dv_nb_r  [D+1][NK];
  logic                   dv_sat_r [D+1][NK];
  logic                   dv_neg_r [D+1][NK];
  logic [CB-1:0]          dv_dm_r  [D+1][NA];
  logic                   dv_par_r [D+1][NA];
  logic                   dv_pm_r  [D+1][NA];

  logic [CB-1:0]          dv_rem_nxt [D+1][NK];
  logic [D-1:0]           dv_q_nxt   [D+1][NK];
  logic [D-1:0]           dv_nb_nxt  [D+1][NK];
  logic                   dv_sat_nxt [D+1][NK];

  always_comb begin
    logic [CB+FB-1:0] nn;
    logic [FB:0]      top;
    logic             sat;
    logic [CB:0]      trial;
    logic [CB:0]      dmk;
    // setup: saturate when the quotient cannot fit below 2^(CB-1)
    for (int k = 0; k < NK; k++) begin
      nn  = {s1_nmag_r[k], {FB{1'b0}}};
      top = nn[CB+FB-1:CB-1];
      sat = CW'(top) >= CW'(s1_dmag_r[k/2]);
      dv_sat_nxt[0][k] = sat;
      dv_rem_nxt[0][k] = sat ? '0 : CB'(top);
      dv_nb_nxt[0][k]  = nn[CB-2:0];
      dv_q_nxt[0][k]   = '0;
    end
    for (int j = 1; j <= D; j++) begin
      for (int k = 0; k < NK; k++) begin
        trial = {dv_rem_r[j-1][k], dv_nb_r[j-1][k][D-1]};
        dmk   = {1'b0, dv_dm_r[j-1][k/2]};
        dv_sat_nxt[j][k] = dv_sat_r[j-1][k];
        dv_nb_nxt[j][k]  = {dv_nb_r[j-1][k][D-2:0], 1'b0};
        if (trial >= dmk) begin
          dv_rem_nxt[j][k] = CB'(trial - dmk);
          dv_q_nxt[j][k]   = {dv_q_r[j-1][k][D-2:0], 1'b1};
        end else begin
          dv_rem_nxt[j][k] = CB'(trial);
          dv_q_nxt[j][k]   = {dv_q_r[j-1][k][D-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- post stages
  logic                   p1_vld_r, p2_vld_r, p3_vld_r;
  logic signed [CB-1:0]   p1_t_r [NK];
  logic [NA-1:0]          p1_par_r;
  logic                   p1_pmiss_r, p2_pmiss_r, p3_pmiss_r;
  logic signed [CB-1:0]   p2_lo_r [NA];
  logic signed [CB-1:0]   p2_hi_r [NA];
  logic signed [CB-1:0]   p3_near_r, p3_far_r;

  logic signed [CB-1:0]   p1_t_nxt [NK];
  logic [NA-1:0]          p1_par_nxt;
  logic                   p1_pmiss_nxt;
  logic signed [CB-1:0]   p2_lo_nxt [NA];
  logic signed [CB-1:0]   p2_hi_nxt [NA];
  logic signed [CB-1:0]   p3_near_nxt, p3_far_nxt;
  logic                   o_hit_nxt;
  logic [D-1:0]           o_dist_nxt;

  always_comb begin
    logic [CB-1:0] mag;
    p1_pmiss_nxt = 1'b0;
    for (int k = 0; k < NK; k++) begin
      mag = dv_sat_r[D][k] ? TMAX : {1'b0, dv_q_r[D][k]};
      p1_t_nxt[k] = dv_neg_r[D][k] ? -$signed(mag) : $signed(mag);
    end
    for (int a = 0; a < NA; a++) begin
      p1_par_nxt[a] = dv_par_r[D][a];
      p1_pmiss_nxt  = p1_pmiss_nxt | (dv_par_r[D][a] & dv_pm_r[D][a]);
    end
  end

  // order the two plane times; a parallel axis leaves the interval unbounded
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      if (p1_par_r[a]) begin
        p2_lo_nxt[a] = -$signed(TMAX);
        p2_hi_nxt[a] = $signed(TMAX);
      end else if (p1_t_r[2*a] > p1_t_r[2*a+1]) begin
        p2_lo_nxt[a] = p1_t_r[2*a+1];
        p2_hi_nxt[a] = p1_t_r[2*a];
      end else begin
        p2_lo_nxt[a] = p1_t_r[2*a];
        p2_hi_nxt[a] = p1_t_r[2*a+1];
      end
    end
  end

  always_comb begin
    logic g01, g02, g12, l01, l02, l12;
    g01 = p2_lo_r[0] >= p2_lo_r[1];
    g02 = p2_lo_r[0] >= p2_lo_r[2];
    g12 = p2_lo_r[1] >= p2_lo_r[2];
    if (g01 && g02)       p3_near_nxt = p2_lo_r[0];
    else if (!g01 && g12) p3_near_nxt = p2_lo_r[1];
    else                  p3_near_nxt = p2_lo_r[2];
    l01 = p2_hi_r[0] <= p2_hi_r[1];
    l02 = p2_hi_r[0] <= p2_hi_r[2];
    l12 = p2_hi_r[1] <= p2_hi_r[2];
    if (l01 && l02)       p3_far_nxt = p2_hi_r[0];
    else if (!l01 && l12) p3_far_nxt = p2_hi_r[1];
    else                  p3_far_nxt = p2_hi_r[2];
  end

  always_comb begin
    logic signed [CB-1:0] t_sel;
    o_hit_nxt  = !p3_pmiss_r && !(p3_near_r > p3_far_r) && !p3_far_r[CB-1];
    t_sel      = p3_near_r[CB-1] ? p3_far_r : p3_near_r;
    o_dist_nxt = o_hit_nxt ? t_sel[D-1:0] : '0;
  end

  logic           out_vld_r;
  logic           out_hit_r;
  logic [D-1:0]   out_dist_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      for (int j = 0; j <= D; j++) dv_vld_r[j] <= 1'b0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_tvalid;
      dv_vld_r[0] <= s1_vld_r;
      for (int j = 1; j <= D; j++) dv_vld_r[j] <= dv_vld_r[j-1];
      p1_vld_r  <= dv_vld_r[D];
      p2_vld_r  <= p1_vld_r;
      p3_vld_r  <= p2_vld_r;
      out_vld_r <= p3_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dmag_r <= s1_dmag_nxt;
      s1_dneg_r <= s1_dneg_nxt;
      s1_pm_r   <= s1_pm_nxt;
      s1_nmag_r <= s1_nmag_nxt;
      s1_nneg_r <= s1_nneg_nxt;
      for (int j = 0; j <= D; j++) begin
        for (int k = 0; k < NK; k++) begin
          dv_rem_r[j][k] <= dv_rem_nxt[j][k];
          dv_q_r[j][k]   <= dv_q_nxt[j][k];
          dv_nb_r[j][k]  <= dv_nb_nxt[j][k];
          dv_sat_r[j][k] <= dv_sat_nxt[j][k];
        end
      end
      for (int k = 0; k < NK; k++) dv_neg_r[0][k] <= s1_nneg_r[k] ^ s1_dneg_r[k/2];
      for (int a = 0; a < NA; a++) begin
        dv_dm_r[0][a]  <= s1_dmag_r[a];
        dv_par_r[0][a] <= s1_dmag_r[a] <= PAR_LIM;
        dv_pm_r[0][a]  <= s1_pm_r[a];
      end
      for (int j = 1; j <= D; j++) begin
        for (int k = 0; k < NK; k++) dv_neg_r[j][k] <= dv_neg_r[j-1][k];
        for (int a = 0; a < NA; a++) begin
          dv_dm_r[j][a]  <= dv_dm_r[j-1][a];
          dv_par_r[j][a] <= dv_par_r[j-1][a];
          dv_pm_r[j][a]  <= dv_pm_r[j-1][a];
        end
      end
      p1_t_r     <= p1_t_nxt;
      p1_par_r   <= p1_par_nxt;
      p1_pmiss_r <= p1_pmiss_nxt;
      p2_lo_r    <= p2_lo_nxt;
      p2_hi_r    <= p2_hi_nxt;
      p2_pmiss_r <= p1_pmiss_r;
      p3_near_r  <= p3_near_nxt;
      p3_far_r   <= p3_far_nxt;
      p3_pmiss_r <= p2_pmiss_r;
      out_hit_r  <= o_hit_nxt;
      out_dist_r <= o_dist_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'({out_dist_r, out_hit_r});

  // a miss always reports zero distance
  `ASSERT_CLK(a_miss_zero, clk, rst_n,
    out_vld_r && !out_hit_r |-> out_dist_r == '0, "miss with nonzero distance")
  // restoring divider keeps its remainder below the divisor
  `ASSERT_CLK(a_rem_bound, clk, rst_n,
    dv_vld_r[D] && !dv_sat_r[D][0] |-> dv_rem_r[D][0] < dv_dm_r[D][0], "divider remainder")
  // a held pipeline keeps its p1 and p3 stage valid bits
  `ASSERT_CLK(a_hold, clk, rst_n,
    !adv |=> $stable(p1_vld_r) && $stable(p3_vld_r), "valid moved while held")
  // reset empties the output stage
  `ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_vld_r, "output valid after reset")

endmodule
